// ----- sv/kmt_pkg.sv -----
// ----------------------------------------------------------------------------
// kmt_pkg: keyboard matrix tracker shared types and constants
// Event codes, keycode-to-matrix map and the structs passed between modules.
// ----------------------------------------------------------------------------
package kmt_pkg;

  // payload field widths
  localparam int FuncW = 2;
  localparam int CodeW = 8;
  localparam int PosW  = 4;

  // event kinds; code 3 means nothing and acts as no event
  typedef enum logic [FuncW-1:0] {
    FUNC_NONE    = 2'd0,
    FUNC_PRESS   = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

  // one keymap entry: valid flag, matrix row, matrix column
  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } map_entry_t;

  // decoded key event handed to the state store
  typedef struct packed {
    logic            press;
    logic            release_key;
    logic            unmapped;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } key_event_t;

  // query answers from the state store
  typedef struct packed {
    logic cell_down;
    logic column_active;
    logic any_down;
  } query_result_t;

  // host keycode to matrix position; entries are valid << 8 | row << 4 | col
  function automatic map_entry_t key_map(input logic [CodeW-1:0] code);
    logic [8:0] e;
    case (code)
      8'd9:   e = 9'h170;
      8'd10:  e = 9'h130;
      8'd11:  e = 9'h131;
      8'd12:  e = 9'h111;
      8'd13:  e = 9'h112;
      8'd14:  e = 9'h113;
      8'd15:  e = 9'h134;
      8'd16:  e = 9'h124;
      8'd17:  e = 9'h115;
      8'd18:  e = 9'h126;
      8'd19:  e = 9'h127;
      8'd20:  e = 9'h117;
      8'd21:  e = 9'h118;
      8'd22:  e = 9'h159;
      8'd23:  e = 9'h160;
      8'd24:  e = 9'h110;
      8'd25:  e = 9'h121;
      8'd26:  e = 9'h122;
      8'd27:  e = 9'h133;
      8'd28:  e = 9'h123;
      8'd29:  e = 9'h144;
      8'd30:  e = 9'h135;
      8'd31:  e = 9'h125;
      8'd32:  e = 9'h136;
      8'd33:  e = 9'h137;
      8'd34:  e = 9'h147;
      8'd35:  e = 9'h138;
      8'd36:  e = 9'h149;
      8'd37:  e = 9'h101;
      8'd38:  e = 9'h141;
      8'd39:  e = 9'h151;
      8'd40:  e = 9'h132;
      8'd41:  e = 9'h143;
      8'd42:  e = 9'h153;
      8'd43:  e = 9'h154;
      8'd44:  e = 9'h145;
      8'd45:  e = 9'h146;
      8'd46:  e = 9'h156;
      8'd47:  e = 9'h157;
      8'd48:  e = 9'h148;
      8'd50:  e = 9'h100;
      8'd51:  e = 9'h158;
      8'd52:  e = 9'h161;
      8'd53:  e = 9'h142;
      8'd54:  e = 9'h152;
      8'd55:  e = 9'h163;
      8'd56:  e = 9'h164;
      8'd57:  e = 9'h155;
      8'd58:  e = 9'h165;
      8'd59:  e = 9'h166;
      8'd60:  e = 9'h167;
      8'd61:  e = 9'h168;
      8'd62:  e = 9'h100;
      8'd65:  e = 9'h162;
      8'd66:  e = 9'h140;
      8'd111: e = 9'h139;
      8'd113: e = 9'h119;
      8'd114: e = 9'h179;
      8'd116: e = 9'h129;
      default: e = 9'h000;
    endcase
    return map_entry_t'(e);
  endfunction

endpackage

// ----- sv/kmt_if.sv -----
// ----------------------------------------------------------------------------
// kmt_if: request and response channels of the keyboard matrix tracker
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kmt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_code;
  logic [3:0] query_row;
  logic [3:0] query_col;

  modport source (output valid, func, key_code, query_row, query_col, input ready);
  modport sink   (input valid, func, key_code, query_row, query_col, output ready);
endinterface

interface kmt_rsp_if;
  logic valid;
  logic ready;
  logic cell_down;
  logic column_active;
  logic any_down;
  logic key_unmapped;

  modport source (output valid, cell_down, column_active, any_down, key_unmapped,
                  input ready);
  modport sink   (input valid, cell_down, column_active, any_down, key_unmapped,
                  output ready);
endinterface

// ----- sv/kmt_decode.sv -----
// ----------------------------------------------------------------------------
// kmt_decode: key event decoder
// Looks up the keycode in the matrix map and qualifies press and release.
// ----------------------------------------------------------------------------
module kmt_decode
  import kmt_pkg::*;
(
  input  logic [FuncW-1:0] func,
  input  logic [CodeW-1:0] key_code,
  output key_event_t       key_event
);

  map_entry_t entry;
  logic       is_key;

  // keymap lookup
  assign entry  = key_map(key_code);
  assign is_key = (func == FUNC_PRESS) || (func == FUNC_RELEASE);

  // only mapped presses and releases reach the store
  always_comb begin
    key_event.press       = (func == FUNC_PRESS) && entry.valid;
    key_event.release_key = (func == FUNC_RELEASE) && entry.valid;
    key_event.unmapped    = is_key && !entry.valid;
    key_event.row         = entry.row;
    key_event.col         = entry.col;
  end

endmodule

// ----- sv/kmt_store.sv -----
// ----------------------------------------------------------------------------
// kmt_store: key matrix state
// Cell flags, per-column counts and total count, updated by one event per
// cycle while apply is high; queries answer from the state after the event.
// ----------------------------------------------------------------------------
module kmt_store
  import kmt_pkg::*;
#(
  parameter int MATRIX_ROWS = 16,
  parameter int MATRIX_COLS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            apply,
  input  key_event_t      key_event,
  input  logic [PosW-1:0] query_row,
  input  logic [PosW-1:0] query_col,
  output query_result_t   result
);

  localparam int RowW  = $clog2(MATRIX_ROWS);
  localparam int ColW  = $clog2(MATRIX_COLS);
  localparam int CntW  = $clog2(MATRIX_ROWS + 1);
  localparam int TotW  = $clog2(MATRIX_ROWS * MATRIX_COLS + 1);
  localparam logic [PosW:0] RowLim = (PosW + 1)'(MATRIX_ROWS);
  localparam logic [PosW:0] ColLim = (PosW + 1)'(MATRIX_COLS);

  logic [MATRIX_ROWS-1:0][MATRIX_COLS-1:0] cells, cells_next;
  logic [MATRIX_COLS-1:0][CntW-1:0]        counts, counts_next;
  logic [TotW-1:0]                         total, total_next;

  logic [RowW-1:0] ev_row;
  logic [ColW-1:0] ev_col;
  logic            was_set;
  logic            do_set;
  logic            do_clear;
  logic            row_ok;
  logic            col_ok;

  // event position and current cell state
  assign ev_row   = key_event.row[RowW-1:0];
  assign ev_col   = key_event.col[ColW-1:0];
  assign was_set  = cells[ev_row][ev_col];
  assign do_set   = apply && key_event.press && !was_set;
  assign do_clear = apply && key_event.release_key && was_set;

  // per-cell next state
  for (genvar r = 0; r < MATRIX_ROWS; r++) begin : g_row
    for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_col
      logic hit;
      assign hit = (ev_row == RowW'(r)) && (ev_col == ColW'(c));
      always_comb begin
        cells_next[r][c] = cells[r][c];
        if (hit && do_set) begin
          cells_next[r][c] = 1'b1;
        end else if (hit && do_clear) begin
          cells_next[r][c] = 1'b0;
        end
      end
    end
  end

  // per-column counts
  for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_cnt
    logic col_hit;
    assign col_hit = (ev_col == ColW'(c));
    always_comb begin
      counts_next[c] = counts[c];
      if (col_hit && do_set) begin
        counts_next[c] = counts[c] + CntW'(1);
      end else if (col_hit && do_clear) begin
        counts_next[c] = counts[c] - CntW'(1);
      end
    end
  end

  // total count
  always_comb begin
    total_next = total;
    if (do_set) begin
      total_next = total + TotW'(1);
    end else if (do_clear) begin
      total_next = total - TotW'(1);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cells  <= '0;
      counts <= '0;
      total  <= '0;
    end else begin
      cells  <= cells_next;
      counts <= counts_next;
      total  <= total_next;
    end
  end

  // queries see the state after this event
  assign row_ok = {1'b0, query_row} < RowLim;
  assign col_ok = {1'b0, query_col} < ColLim;

  always_comb begin
    result.cell_down     = row_ok && col_ok &&
                           cells_next[query_row[RowW-1:0]][query_col[ColW-1:0]];
    result.column_active = col_ok && (counts_next[query_col[ColW-1:0]] != '0);
    result.any_down      = (total_next != '0);
  end

endmodule

// ----- sv/keyboard_matrix_tracker.sv -----
// ----------------------------------------------------------------------------
// keyboard_matrix_tracker: emulated keyboard matrix key state
// Tracks pressed keys by host keycode and answers cell, column and
// any-key queries after each event.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   func, key_code, query_row, query_col
//  rsp      out  cell_down, column_active, any_down, key_unmapped
//
//  One request per cycle while rsp is not stalled; each request passes through
//  the input register, then the result register. The event update and the
//  queries sit in one combinational pass between those registers.
//  Reset clears all cell flags and counts at once.
//  A stalled response holds; req stays ready while the input register is
//  empty or can move into the result register.
// ----------------------------------------------------------------------------
module keyboard_matrix_tracker
  import kmt_pkg::*;
#(
  parameter int MATRIX_ROWS = 16,
  parameter int MATRIX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst,
  kmt_req_if.sink    req,
  kmt_rsp_if.source  rsp
);

  logic             s1_valid;
  logic [FuncW-1:0] s1_func;
  logic [CodeW-1:0] s1_code;
  logic [PosW-1:0]  s1_qrow;
  logic [PosW-1:0]  s1_qcol;
  logic             out_free;
  logic             s1_adv;
  key_event_t       key_event;
  query_result_t    query;

  // flow control
  assign out_free  = !rsp.valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_func <= req.func;
      s1_code <= req.key_code;
      s1_qrow <= req.query_row;
      s1_qcol <= req.query_col;
    end
  end

  // keycode decode
  kmt_decode u_decode (
    .func      (s1_func),
    .key_code  (s1_code),
    .key_event (key_event)
  );

  // matrix state and queries
  kmt_store #(
    .MATRIX_ROWS (MATRIX_ROWS),
    .MATRIX_COLS (MATRIX_COLS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .apply     (s1_adv),
    .key_event (key_event),
    .query_row (s1_qrow),
    .query_col (s1_qcol),
    .result    (query)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.cell_down     <= query.cell_down;
      rsp.column_active <= query.column_active;
      rsp.any_down      <= query.any_down;
      rsp.key_unmapped  <= key_event.unmapped;
    end
  end

  // a pressed cell implies its column and the matrix are active
  a_cell_implies_col: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.cell_down |-> rsp.column_active && rsp.any_down)
    else $error("cell down without active column or any key");

  a_col_implies_any: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.column_active |-> rsp.any_down)
    else $error("active column without any key down");

  // query-only requests never flag an unmapped key
  a_no_event_mapped: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !(s1_func == FUNC_PRESS || s1_func == FUNC_RELEASE)
    |=> !rsp.key_unmapped)
    else $error("unmapped flag on a request without key event");

  // a waiting response does not block an empty input register
  a_ready_while_stalled: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req.ready)
    else $error("request blocked with empty input register");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: keyboard_matrix_tracker testbench
// Drives press, release and query requests through the req channel, keeps
// its own copy of the key matrix state to predict every response, and
// compares each rsp field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import kmt_pkg::*;

  localparam int MATRIX_ROWS = 16;
  localparam int MATRIX_COLS = 16;

  // event code with no meaning; the block treats it as no event
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 26;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 40;

  // keycodes picked out for the directed part
  localparam logic [7:0] KEY_NONE_LOW    = 8'd0;
  localparam logic [7:0] KEY_NONE_GAP    = 8'd49;
  localparam logic [7:0] KEY_NONE_HIGH   = 8'd255;
  localparam logic [7:0] KEY_ROW7_COL0   = 8'd9;
  localparam logic [7:0] KEY_ROW0_COL1   = 8'd37;
  localparam logic [7:0] KEY_ROW2_COL9   = 8'd116;
  localparam logic [7:0] KEY_ROW5_COL9   = 8'd22;
  localparam logic [7:0] KEY_ROW7_COL9   = 8'd114;
  localparam logic [7:0] KEY_SHIFT_LEFT  = 8'd50;
  localparam logic [7:0] KEY_SHIFT_RIGHT = 8'd62;

  // matrix layout: one entry per mapped keycode, {code, row, col}
  localparam int NUM_KEYS = 59;
  localparam logic [NUM_KEYS*16-1:0] KEY_CELLS = {
    16'h0970, 16'h0A30, 16'h0B31, 16'h0C11, 16'h0D12, 16'h0E13, 16'h0F34, 16'h1024,
    16'h1115, 16'h1226, 16'h1327, 16'h1417, 16'h1518, 16'h1659, 16'h1760, 16'h1810,
    16'h1921, 16'h1A22, 16'h1B33, 16'h1C23, 16'h1D44, 16'h1E35, 16'h1F25, 16'h2036,
    16'h2137, 16'h2247, 16'h2338, 16'h2449, 16'h2501, 16'h2641, 16'h2751, 16'h2832,
    16'h2943, 16'h2A53, 16'h2B54, 16'h2C45, 16'h2D46, 16'h2E56, 16'h2F57, 16'h3048,
    16'h3200, 16'h3358, 16'h3461, 16'h3542, 16'h3652, 16'h3763, 16'h3864, 16'h3955,
    16'h3A65, 16'h3B66, 16'h3C67, 16'h3D68, 16'h3E00, 16'h4162, 16'h4240, 16'h6F39,
    16'h7119, 16'h7279, 16'h7429
  };

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_code;
    logic [3:0] query_row;
    logic [3:0] query_col;
  } key_req_t;

  typedef struct packed {
    logic cell_down;
    logic column_active;
    logic any_down;
    logic key_unmapped;
  } key_rsp_t;

  logic clk;
  logic rst;

  kmt_req_if req_ch ();
  kmt_rsp_if rsp_ch ();

  keyboard_matrix_tracker #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // predicted matrix state
  logic [15:0] held_rows [16];
  logic [4:0]  held_per_col [16];
  logic [8:0]  held_total;

  key_rsp_t pending_answers [$];
  int       mismatches;
  int       answers_seen;
  int       quiet_cycles;
  bit       tx_steady;
  bit       rx_steady;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // matrix position of a keycode; returns 0 when the code has none
  function automatic logic lookup_cell(input logic [7:0] code, output logic [3:0] row,
                                       output logic [3:0] col);
    logic [15:0] entry;
    row = '0;
    col = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      entry = KEY_CELLS[(NUM_KEYS-1-i)*16 +: 16];
      if (entry[15:8] == code) begin
        row = entry[7:4];
        col = entry[3:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] key_at(input int idx);
    return KEY_CELLS[(NUM_KEYS-1-idx)*16+8 +: 8];
  endfunction

  function automatic logic [7:0] random_key();
    return key_at(int'($urandom_range(NUM_KEYS-1)));
  endfunction

  function automatic key_req_t make_request(input logic [1:0] f, input logic [7:0] code,
                                            input logic [3:0] row, input logic [3:0] col);
    key_req_t r;
    r.func      = f;
    r.key_code  = code;
    r.query_row = row;
    r.query_col = col;
    return r;
  endfunction

  // apply one event to the predicted matrix and answer its query
  function automatic key_rsp_t apply_key_event(input key_req_t r);
    key_rsp_t ans;
    logic [3:0] row;
    logic [3:0] col;
    ans = '0;
    if (r.func == FUNC_PRESS || r.func == FUNC_RELEASE) begin
      if (!lookup_cell(r.key_code, row, col)) begin
        ans.key_unmapped = 1'b1;
      end else if (r.func == FUNC_PRESS && !held_rows[row][col]) begin
        held_rows[row][col] = 1'b1;
        held_per_col[col]   = held_per_col[col] + 5'd1;
        held_total          = held_total + 9'd1;
      end else if (r.func == FUNC_RELEASE && held_rows[row][col]) begin
        held_rows[row][col] = 1'b0;
        held_per_col[col]   = held_per_col[col] - 5'd1;
        held_total          = held_total - 9'd1;
      end
    end
    ans.cell_down = int'(r.query_row) < MATRIX_ROWS && int'(r.query_col) < MATRIX_COLS &&
                    held_rows[r.query_row][r.query_col];
    ans.column_active = int'(r.query_col) < MATRIX_COLS && held_per_col[r.query_col] != 5'd0;
    ans.any_down = held_total != 9'd0;
    return ans;
  endfunction

  // mixed traffic, releases leaning toward keys that are down
  function automatic key_req_t random_request();
    key_req_t r;
    int pick;
    logic [3:0] row;
    logic [3:0] col;
    pick = int'($urandom_range(99));
    if (pick < 40) begin
      r.func = FUNC_PRESS;
    end else if (pick < 72) begin
      r.func = FUNC_RELEASE;
    end else if (pick < 88) begin
      r.func = FUNC_NONE;
    end else begin
      r.func = FUNC_UNUSED;
    end
    r.key_code = ($urandom_range(99) < 75) ? random_key() : 8'($urandom_range(255));
    if (r.func == FUNC_RELEASE && held_total != 9'd0) begin
      for (int tries = 0; tries < 8; tries++) begin
        if (lookup_cell(r.key_code, row, col) && held_rows[row][col]) break;
        r.key_code = random_key();
      end
    end
    if (lookup_cell(r.key_code, row, col) && $urandom_range(99) < 50) begin
      r.query_row = row;
      r.query_col = col;
    end else begin
      r.query_row = 4'($urandom_range(15));
      r.query_col = 4'($urandom_range(15));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: response %0d %s: got %0b, expected %0b",
               $time, answers_seen, what, got, want);
  endtask

  // send one request, with random idle cycles ahead of it
  task automatic send_request(input key_req_t r);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid     <= 1'b0;
      req_ch.func      <= 2'($urandom_range(3));
      req_ch.key_code  <= 8'($urandom_range(255));
      req_ch.query_row <= 4'($urandom_range(15));
      req_ch.query_col <= 4'($urandom_range(15));
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= r.func;
    req_ch.key_code  <= r.key_code;
    req_ch.query_row <= r.query_row;
    req_ch.query_col <= r.query_col;
    do @(posedge clk); while (!req_ch.ready);
    pending_answers.push_back(apply_key_event(r));
  endtask

  // hold the sender until every response is back
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // extremes, unmapped codes, repeats, shared cell, stale releases
  task automatic test_directed();
    send_request(make_request(FUNC_NONE, KEY_NONE_LOW, 4'd0, 4'd0));
    send_request(make_request(FUNC_NONE, KEY_NONE_HIGH, 4'd15, 4'd15));
    send_request(make_request(FUNC_PRESS, KEY_NONE_LOW, 4'd0, 4'd0));
    send_request(make_request(FUNC_RELEASE, KEY_NONE_HIGH, 4'd15, 4'd0));
    send_request(make_request(FUNC_PRESS, KEY_NONE_GAP, 4'd0, 4'd15));
    send_request(make_request(FUNC_UNUSED, KEY_ROW7_COL0, 4'd7, 4'd0));
    send_request(make_request(FUNC_PRESS, KEY_ROW7_COL0, 4'd7, 4'd0));
    send_request(make_request(FUNC_PRESS, KEY_ROW7_COL0, 4'd7, 4'd0));
    send_request(make_request(FUNC_UNUSED, KEY_NONE_HIGH, 4'd15, 4'd15));
    send_request(make_request(FUNC_RELEASE, KEY_ROW7_COL9, 4'd7, 4'd9));
    send_request(make_request(FUNC_PRESS, KEY_ROW2_COL9, 4'd2, 4'd9));
    send_request(make_request(FUNC_PRESS, KEY_ROW7_COL9, 4'd7, 4'd9));
    send_request(make_request(FUNC_PRESS, KEY_ROW5_COL9, 4'd0, 4'd9));
    send_request(make_request(FUNC_RELEASE, KEY_ROW2_COL9, 4'd2, 4'd9));
    send_request(make_request(FUNC_RELEASE, KEY_ROW7_COL9, 4'd7, 4'd9));
    send_request(make_request(FUNC_RELEASE, KEY_ROW5_COL9, 4'd5, 4'd9));
    send_request(make_request(FUNC_PRESS, KEY_SHIFT_LEFT, 4'd0, 4'd0));
    send_request(make_request(FUNC_PRESS, KEY_SHIFT_RIGHT, 4'd0, 4'd0));
    send_request(make_request(FUNC_RELEASE, KEY_SHIFT_RIGHT, 4'd0, 4'd0));
    send_request(make_request(FUNC_RELEASE, KEY_SHIFT_LEFT, 4'd0, 4'd0));
    send_request(make_request(FUNC_RELEASE, KEY_ROW7_COL0, 4'd7, 4'd0));
    send_request(make_request(FUNC_PRESS, KEY_ROW0_COL1, 4'd0, 4'd1));
    send_request(make_request(FUNC_RELEASE, KEY_ROW0_COL1, 4'd15, 4'd1));
  endtask

  // press a handful of keys, then let them all go in random order
  task automatic test_typing_bursts(input int bursts);
    logic [7:0] down_keys [$];
    logic [7:0] code;
    logic [3:0] row;
    logic [3:0] col;
    int idx;
    repeat (bursts) begin
      repeat ($urandom_range(6, 1)) begin
        code = random_key();
        down_keys.push_back(code);
        void'(lookup_cell(code, row, col));
        send_request(make_request(FUNC_PRESS, code, row, col));
        if ($urandom_range(99) < 30)
          send_request(make_request(FUNC_NONE, 8'($urandom_range(255)),
                                    4'($urandom_range(15)), col));
      end
      while (down_keys.size() != 0) begin
        idx  = int'($urandom_range(down_keys.size() - 1));
        code = down_keys[idx];
        down_keys.delete(idx);
        void'(lookup_cell(code, row, col));
        send_request(make_request(FUNC_RELEASE, code, 4'($urandom_range(15)), col));
      end
    end
  endtask

  task automatic test_mixed_traffic(input int items);
    repeat (items) send_request(random_request());
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int items);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (items) send_request(random_request());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // every key down at once, then all released
  task automatic test_full_matrix();
    logic [3:0] row;
    logic [3:0] col;
    for (int i = 0; i < NUM_KEYS; i++) begin
      void'(lookup_cell(key_at(i), row, col));
      send_request(make_request(FUNC_PRESS, key_at(i), row, col));
    end
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      void'(lookup_cell(key_at(i), row, col));
      send_request(make_request(FUNC_RELEASE, key_at(i), 4'($urandom_range(15)), col));
    end
  endtask

  // response side stalls
  always @(posedge clk) begin
    rsp_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each response with the oldest prediction
  always @(posedge clk) begin : check_responses
    key_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("arrived with no request pending", 1'b1, 1'b0);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.cell_down !== want.cell_down)
          report_mismatch("cell_down", rsp_ch.cell_down, want.cell_down);
        if (rsp_ch.column_active !== want.column_active)
          report_mismatch("column_active", rsp_ch.column_active, want.column_active);
        if (rsp_ch.any_down !== want.any_down)
          report_mismatch("any_down", rsp_ch.any_down, want.any_down);
        if (rsp_ch.key_unmapped !== want.key_unmapped)
          report_mismatch("key_unmapped", rsp_ch.key_unmapped, want.key_unmapped);
      end
    end
  end

  // watchdog on cycles with no request or response moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, pending_answers.size());
      $display("** keyboard_matrix_tracker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_NONE;
    req_ch.key_code  <= '0;
    req_ch.query_row <= '0;
    req_ch.query_col <= '0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    foreach (held_rows[i]) begin
      held_rows[i]    = '0;
      held_per_col[i] = '0;
    end
    held_total = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_for_responses();
    test_typing_bursts(75);
    wait_for_responses();
    test_mixed_traffic(450);
    test_back_to_back(250);
    test_full_matrix();
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** keyboard_matrix_tracker: PASSED **");
    end else begin
      $display("** keyboard_matrix_tracker: FAILED **");
    end
    $finish;
  end

endmodule
